>>> rtl/core/lbl_pkg.sv
// ----------------------------------------------------------------------------
// Leaky-bucket limiter package
// Shared types, constants and helpers of the per-key leaky-bucket limiter.
// ----------------------------------------------------------------------------
package lbl_pkg;

  localparam int unsigned ENTRIES_DEF  = 256;
  localparam int unsigned KEY_BITS_DEF = 64;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned EXC_W    = 32;
  localparam int unsigned RATE_W   = 30;
  localparam int unsigned BURST_W  = 20;
  localparam int unsigned PROD_W   = RATE_W + TIME_W;
  localparam int unsigned DIV_W    = 43;
  localparam int unsigned REM_W    = 10;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned DIV_SPLIT   = 22;
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h10624DD3;

  localparam logic [TIME_W-1:0] IDLE_LIMIT_MS = 32'd60000;
  localparam logic [REM_W:0]    MILLI         = 11'd1000;

  localparam logic [1:0] REG_DRAIN_RATE  = 2'd0;
  localparam logic [1:0] REG_BURST_LIMIT = 2'd1;
  localparam logic [1:0] REG_NO_DELAY    = 2'd2;

  localparam logic [RATE_W-1:0]  DRAIN_RATE_RST = 30'd1000;

  typedef enum logic [1:0] {
    VERDICT_PASS   = 2'd0,
    VERDICT_DELAY  = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_MOVE   = 2'd2,
    CELL_INSERT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [63:0] flow_key;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] delay_ms;
    logic [31:0] excess_milli;
    logic        inserted;
  } res_t;

  typedef struct packed {
    cell_op_e          op;
    logic [TIME_W-1:0] new_time;
    logic [EXC_W-1:0]  new_exc;
  } cell_ctl_t;

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] last);
    logic [TIME_W-1:0] d;
    d = now - last;
    return d[TIME_W-1] ? (~d + 1'b1) : d;
  endfunction

endpackage

>>> rtl/core/lbl_cell.sv
// ----------------------------------------------------------------------------
// Limiter table cell
// One table entry in recency order: matches the lookup key and shifts, moves or inserts.
// ----------------------------------------------------------------------------
module lbl_cell #(
  parameter int unsigned KEY_BITS = lbl_pkg::KEY_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lbl_pkg::cell_ctl_t        ctl_i,
  input  logic [KEY_BITS-1:0]       key_i,
  input  logic                      sel_i,
  input  logic                      left_valid_i,
  input  logic [KEY_BITS-1:0]       left_key_i,
  input  logic [lbl_pkg::TIME_W-1:0] left_time_i,
  input  logic [lbl_pkg::EXC_W-1:0] left_exc_i,
  input  logic                      right_valid_i,
  output logic                      valid_o,
  output logic [KEY_BITS-1:0]       key_o,
  output logic [lbl_pkg::TIME_W-1:0] time_o,
  output logic [lbl_pkg::EXC_W-1:0] exc_o,
  output logic                      match_o
);
  import lbl_pkg::*;

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [EXC_W-1:0]    exc_q, exc_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    time_d  = time_q;
    exc_d   = exc_q;
    case (ctl_i.op)
      CELL_SHIFT: begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        time_d  = left_time_i;
        exc_d   = left_exc_i;
      end
      CELL_MOVE: begin
        if (sel_i && left_valid_i) begin
          key_d  = left_key_i;
          time_d = left_time_i;
          exc_d  = left_exc_i;
        end else if (sel_i) begin
          key_d  = key_i;
          time_d = ctl_i.new_time;
          exc_d  = ctl_i.new_exc;
        end
      end
      CELL_INSERT: begin
        if (!valid_q && right_valid_i) begin
          valid_d = 1'b1;
          key_d   = key_i;
          time_d  = ctl_i.new_time;
          exc_d   = ctl_i.new_exc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    time_q <= time_d;
    exc_q  <= exc_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign time_o  = time_q;
  assign exc_o   = exc_q;
  assign match_o = valid_q && (key_q == key_i);

endmodule

>>> rtl/core/lbl_div.sv
// ----------------------------------------------------------------------------
// Limiter divider
// Division by one thousand by reciprocal multiplication in two digits, through
// a high-digit, a remainder and a low-digit step.
// ----------------------------------------------------------------------------
module lbl_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lbl_pkg::DIV_W-1:0] num_i,
  output logic                     busy_o,
  output logic [lbl_pkg::DIV_W-1:0] quot_o
);
  import lbl_pkg::*;

  localparam int unsigned LO_W  = DIV_SPLIT;
  localparam int unsigned HI_W  = DIV_W - DIV_SPLIT;
  localparam int unsigned MUL_W = 32 + RECIP_W;

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_HI   = 4'b0010,
    DV_REM  = 4'b0100,
    DV_LO   = 4'b1000
  } div_state_e;

  div_state_e       state_q;
  logic [HI_W-1:0]  nh_q;
  logic [HI_W-1:0]  qh_q;
  logic [LO_W-1:0]  nl_q;
  logic [31:0]      x_q;
  logic [DIV_W-1:0] quot_q;
  logic [31:0]      mul_a;
  logic [MUL_W-1:0] mul_p;
  logic [HI_W-1:0]  rem_w;

  assign mul_a = (state_q == DV_HI) ? 32'(nh_q) : x_q;
  assign mul_p = MUL_W'(mul_a) * MUL_W'(RECIP_1000);
  assign rem_w = nh_q - HI_W'(qh_q * HI_W'(MILLI));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else if (start_i) begin
      state_q <= DV_HI;
    end else begin
      case (state_q)
        DV_HI:   state_q <= DV_REM;
        DV_REM:  state_q <= DV_LO;
        DV_LO:   state_q <= DV_IDLE;
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nh_q <= num_i[DIV_W-1:LO_W];
      nl_q <= num_i[LO_W-1:0];
    end else begin
      case (state_q)
        DV_HI: begin
          qh_q <= mul_p[RECIP_SHIFT +: HI_W];
        end
        DV_REM: begin
          x_q <= {rem_w[REM_W-1:0], nl_q};
        end
        DV_LO: begin
          quot_q <= {qh_q, mul_p[RECIP_SHIFT +: LO_W]};
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_o = (state_q != DV_IDLE);
  assign quot_o = quot_q;

endmodule

>>> rtl/core/per_key_leaky_bucket_limiter.sv
// ----------------------------------------------------------------------------
// Per-key leaky-bucket limiter
// Rate limiter over a recency-ordered row of flow cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// for the whole transaction. The result appears on res_o for one cycle with
// result_valid_o in the same cycle as busy falls and cannot be held off by the
// receiver; a new request may already be taken in that cycle.
// The table is a row of cells kept in recency order, newest nearest cell 0
// and the least recently used entry always in the last cell, so the expiry
// checks read a fixed cell and every relink is a shift along the row.
// Each tail expiry check goes through TMUL and TCMP on the shared multiplier.
// A miss runs the tail checks, MATCH, GATHER and INS, with an eviction and more
// tail checks first when the table is full; a hit runs the tail checks, MATCH,
// GATHER, HMUL, HCMP, DIV to divide a positive drained excess by one thousand,
// and HWR. One request is handled at a time, taken only while busy is low.
// Configuration uses the APB port with pready always high; writes are
// expected only while busy is low. Reset empties the table, restores the
// register defaults and clears any pending result.
// ----------------------------------------------------------------------------
module per_key_leaky_bucket_limiter #(
  parameter int unsigned ENTRIES  = lbl_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lbl_pkg::KEY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lbl_pkg::req_t              req_i,
  output logic                       result_valid_o,
  output lbl_pkg::res_t              res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbl_pkg::ADDR_W-1:0] paddr,
  input  logic [lbl_pkg::DATA_W-1:0] pwdata,
  output logic [lbl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lbl_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_TMUL   = 10'b0000000010,
    ST_TCMP   = 10'b0000000100,
    ST_MATCH  = 10'b0000001000,
    ST_GATHER = 10'b0000010000,
    ST_HMUL   = 10'b0000100000,
    ST_HCMP   = 10'b0001000000,
    ST_DIV    = 10'b0010000000,
    ST_HWR    = 10'b0100000000,
    ST_INS    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [RATE_W-1:0]  rate_q;
  logic [BURST_W-1:0] burst_q;
  logic               nodelay_q;

  logic [KEY_BITS-1:0] key_q;
  logic [TIME_W-1:0]   now_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                chk_q, chk_d;
  logic                evict_q, evict_d;

  logic [TIME_W-1:0] ms_q;
  logic [PROD_W-1:0] prod_q;
  logic [DIV_W-1:0]  cmp_q;
  logic [EXC_W-1:0]  hexc_q;
  logic [TIME_W-1:0] htime_q;
  logic [EXC_W-1:0]  e_q;
  logic [ENTRIES-1:0] hit_q, sel_q;

  res_t res_q;
  logic res_valid_q;

  cell_ctl_t          ctl;
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] cell_match;
  logic [KEY_BITS-1:0] cell_key  [ENTRIES];
  logic [TIME_W-1:0]   cell_time [ENTRIES];
  logic [EXC_W-1:0]    cell_exc  [ENTRIES];

  logic [TIME_W-1:0]  g_time;
  logic [EXC_W-1:0]   g_exc;
  logic [ENTRIES-1:0] reach;
  logic               found;
  logic               full;
  logic               expire;
  state_e             after_chk;
  logic [TIME_W-1:0]  ms_w;
  logic               div_start;
  logic               div_busy;
  logic [DIV_W-1:0]   div_num;
  logic [DIV_W-1:0]   div_quot;
  logic [EXC_W-1:0]   e_sat;
  logic [EXC_W-1:0]   burst_milli;
  logic               cfg_wr;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic                left_valid;
    logic [KEY_BITS-1:0] left_key;
    logic [TIME_W-1:0]   left_time;
    logic [EXC_W-1:0]    left_exc;
    logic                right_valid;
    if (k == 0) begin : g_first
      assign left_valid = 1'b0;
      assign left_key   = '0;
      assign left_time  = '0;
      assign left_exc   = '0;
    end else begin : g_inner
      assign left_valid = cell_valid[k-1];
      assign left_key   = cell_key[k-1];
      assign left_time  = cell_time[k-1];
      assign left_exc   = cell_exc[k-1];
    end
    if (k == ENTRIES - 1) begin : g_last
      assign right_valid = 1'b1;
    end else begin : g_mid
      assign right_valid = cell_valid[k+1];
    end
    lbl_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .sel_i        (sel_q[k]),
      .left_valid_i (left_valid),
      .left_key_i   (left_key),
      .left_time_i  (left_time),
      .left_exc_i   (left_exc),
      .right_valid_i(right_valid),
      .valid_o      (cell_valid[k]),
      .key_o        (cell_key[k]),
      .time_o       (cell_time[k]),
      .exc_o        (cell_exc[k]),
      .match_o      (cell_match[k])
    );
  end

  lbl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  always_comb begin
    g_time = '0;
    g_exc  = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (hit_q[k]) begin
        g_time = g_time | cell_time[k];
        g_exc  = g_exc | cell_exc[k];
      end
    end
    reach = hit_q;
    for (int s = 1; s < ENTRIES; s = s * 2) begin
      reach = reach | (reach >> s);
    end
  end

  assign found       = |hit_q;
  assign full        = (count_q == CNT_W'(ENTRIES));
  assign expire      = (ms_q >= IDLE_LIMIT_MS) && (PROD_W'(cmp_q) <= prod_q);
  assign after_chk   = evict_q ? ST_INS : ST_MATCH;
  assign ms_w        = elapsed(now_q, (state_q == ST_HMUL) ? htime_q
                                                            : cell_time[ENTRIES-1]);
  assign div_num     = DIV_W'(PROD_W'(cmp_q) - prod_q) + DIV_W'(MILLI - 1'b1);
  assign e_sat       = (|div_quot[DIV_W-1:EXC_W]) ? '1 : div_quot[EXC_W-1:0];
  assign burst_milli = EXC_W'(burst_q) * EXC_W'(MILLI);
  assign div_start   = (state_q == ST_HCMP) && (PROD_W'(cmp_q) > prod_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    chk_d        = chk_q;
    evict_d      = evict_q;
    ctl.op       = CELL_HOLD;
    ctl.new_time = now_q;
    ctl.new_exc  = (state_q == ST_HWR) ? e_q : '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_TMUL;
          chk_d   = 1'b0;
          evict_d = 1'b0;
        end
      end
      ST_TMUL: begin
        state_d = (count_q == '0) ? after_chk : ST_TCMP;
      end
      ST_TCMP: begin
        if (expire) begin
          ctl.op  = CELL_SHIFT;
          count_d = count_q - 1'b1;
          chk_d   = 1'b1;
          state_d = chk_q ? after_chk : ST_TMUL;
        end else begin
          state_d = after_chk;
        end
      end
      ST_MATCH: begin
        state_d = ST_GATHER;
      end
      ST_GATHER: begin
        if (found) begin
          state_d = ST_HMUL;
        end else if (full) begin
          ctl.op  = CELL_SHIFT;
          count_d = count_q - 1'b1;
          chk_d   = 1'b0;
          evict_d = 1'b1;
          state_d = ST_TMUL;
        end else begin
          state_d = ST_INS;
        end
      end
      ST_HMUL: begin
        state_d = ST_HCMP;
      end
      ST_HCMP: begin
        state_d = div_start ? ST_DIV : ST_HWR;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_HWR;
        end
      end
      ST_HWR: begin
        ctl.op  = CELL_MOVE;
        state_d = ST_IDLE;
      end
      ST_INS: begin
        ctl.op  = CELL_INSERT;
        count_d = count_q + 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      chk_q       <= 1'b0;
      evict_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_q       <= chk_d;
      evict_q     <= evict_d;
      res_valid_q <= (state_q == ST_HWR) || (state_q == ST_INS);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          key_q <= req_i.flow_key[KEY_BITS-1:0];
          now_q <= req_i.now_ms;
        end
      end
      ST_TMUL: begin
        ms_q   <= ms_w;
        prod_q <= PROD_W'(rate_q) * PROD_W'(ms_w);
        cmp_q  <= DIV_W'(cell_exc[ENTRIES-1]) * DIV_W'(MILLI);
      end
      ST_MATCH: begin
        hit_q <= cell_match;
      end
      ST_GATHER: begin
        htime_q <= g_time;
        hexc_q  <= g_exc;
        sel_q   <= reach & cell_valid;
      end
      ST_HMUL: begin
        ms_q   <= ms_w;
        prod_q <= PROD_W'(rate_q) * PROD_W'(ms_w);
        cmp_q  <= (DIV_W'(hexc_q) + DIV_W'(MILLI)) * DIV_W'(MILLI);
      end
      ST_HCMP: begin
        e_q <= '0;
      end
      ST_DIV: begin
        if (!div_busy) begin
          e_q <= e_sat;
        end
      end
      ST_HWR: begin
        res_q.inserted     <= 1'b0;
        res_q.excess_milli <= e_q;
        if (e_q > burst_milli) begin
          res_q.verdict  <= VERDICT_REJECT;
          res_q.delay_ms <= '0;
        end else if ((e_q != '0) && !nodelay_q) begin
          res_q.verdict  <= VERDICT_DELAY;
          res_q.delay_ms <= e_q;
        end else begin
          res_q.verdict  <= VERDICT_PASS;
          res_q.delay_ms <= '0;
        end
      end
      ST_INS: begin
        res_q.inserted     <= 1'b1;
        res_q.excess_milli <= '0;
        res_q.verdict      <= VERDICT_PASS;
        res_q.delay_ms     <= '0;
      end
      default: begin
      end
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= DRAIN_RATE_RST;
      burst_q   <= '0;
      nodelay_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DRAIN_RATE:  rate_q    <= pwdata[RATE_W-1:0];
        REG_BURST_LIMIT: burst_q   <= pwdata[BURST_W-1:0];
        REG_NO_DELAY:    nodelay_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DRAIN_RATE:  prdata = DATA_W'(rate_q);
      REG_BURST_LIMIT: prdata = DATA_W'(burst_q);
      REG_NO_DELAY:    prdata = DATA_W'(nodelay_q);
      default:         prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a transaction in progress");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("fill count exceeds table size");

  a_tail_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !cell_valid[ENTRIES-1])
    else $error("tail cell disagrees with fill count");

endmodule

>>> sim/tb_per_key_leaky_bucket_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-key leaky-bucket limiter testbench
// Drives flow requests in random bursts, predicts each verdict with a
// self-contained model of the LRU flow table and its leaky buckets, and checks
// every result transaction field by field across several register settings.
// ----------------------------------------------------------------------------
module tb_per_key_leaky_bucket_limiter;
  import lbl_pkg::*;

  localparam int NSLOT = 256;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  req_t                req_i;
  logic                result_valid_o;
  res_t                res_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  per_key_leaky_bucket_limiter u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .result_valid_o(result_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Flow table shadow and register shadow.
  logic [63:0] flow_key_tab [NSLOT];
  logic [31:0] seen_tab [NSLOT];
  logic [31:0] excess_tab [NSLOT];
  bit          live_tab [NSLOT];
  int          older [NSLOT];
  int          newer [NSLOT];
  int          mru, lru, n_live;
  logic [29:0] rate_cfg;
  logic [19:0] burst_cfg;
  logic        nodelay_cfg;

  req_t  pending_reqs[$];
  res_t  expected_verdicts[$];
  int    errors;
  int    burst_left, gap_left;
  logic [31:0] clock_ms;
  logic [63:0] key_pool [40];

  function automatic logic [31:0] idle_ms(logic [31:0] now, logic [31:0] last);
    logic [31:0] d;
    d = now - last;
    if (d[31]) d = -d;
    return d;
  endfunction

  function automatic logic [63:0] drained(logic [31:0] ms);
    return (64'(rate_cfg) * 64'(ms)) / 64'd1000;
  endfunction

  function automatic void drop_lru();
    if (n_live == 0) return;
    live_tab[lru] = 0;
    if (n_live > 1) lru = older[lru];
    n_live--;
  endfunction

  function automatic void expire_idle(int checks, logic [31:0] now);
    logic [31:0] ms;
    for (int k = 0; k < checks; k++) begin
      if (n_live == 0) return;
      ms = idle_ms(now, seen_tab[lru]);
      if (ms < 32'd60000) return;
      if (64'(excess_tab[lru]) > drained(ms)) return;
      drop_lru();
    end
  endfunction

  function automatic void promote(int i);
    int p, n;
    if (i == mru) return;
    p = older[i];
    n = newer[i];
    newer[p] = n;
    if (i == lru) lru = p;
    else older[n] = p;
    newer[i] = mru;
    older[mru] = i;
    mru = i;
  endfunction

  function automatic res_t predict_verdict(req_t r);
    res_t  o;
    int    hit, slot;
    logic [63:0] e, d;
    hit = -1;
    o = '0;
    o.verdict = VERDICT_PASS;
    expire_idle(2, r.now_ms);
    for (int i = 0; i < NSLOT; i++)
      if (hit < 0 && live_tab[i] && flow_key_tab[i] == r.flow_key) hit = i;
    if (hit >= 0) begin
      e = 64'(excess_tab[hit]) + 64'd1000;
      d = drained(idle_ms(r.now_ms, seen_tab[hit]));
      e = (d >= e) ? 64'd0 : e - d;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      excess_tab[hit] = e[31:0];
      seen_tab[hit] = r.now_ms;
      promote(hit);
      o.excess_milli = e[31:0];
      if (e > 64'(burst_cfg) * 64'd1000) o.verdict = VERDICT_REJECT;
      else if (e != 0 && !nodelay_cfg) begin
        o.verdict = VERDICT_DELAY;
        o.delay_ms = e[31:0];
      end
      return o;
    end
    if (n_live >= NSLOT) begin
      drop_lru();
      expire_idle(2, r.now_ms);
    end
    slot = 0;
    while (slot < NSLOT && live_tab[slot]) slot++;
    if (slot >= NSLOT) slot = 0;
    flow_key_tab[slot] = r.flow_key;
    seen_tab[slot] = r.now_ms;
    excess_tab[slot] = '0;
    live_tab[slot] = 1;
    newer[slot] = mru;
    if (n_live == 0) lru = slot;
    else older[mru] = slot;
    mru = slot;
    n_live++;
    o.inserted = 1'b1;
    return o;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else begin
        start <= (pending_reqs.size() > 0);
        if (pending_reqs.size() > 0) req_i <= pending_reqs[0];
      end
    end
  end

  // Acceptance, prediction and result checking.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, res_o);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (res_o.verdict !== want.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                     res_o.verdict);
            errors++;
          end
          if (res_o.delay_ms !== want.delay_ms) begin
            $display("%0t: delay_ms expected %0d actual %0d", $time, want.delay_ms,
                     res_o.delay_ms);
            errors++;
          end
          if (res_o.excess_milli !== want.excess_milli) begin
            $display("%0t: excess_milli expected %0d actual %0d", $time,
                     want.excess_milli, res_o.excess_milli);
            errors++;
          end
          if (res_o.inserted !== want.inserted) begin
            $display("%0t: inserted expected %0d actual %0d", $time, want.inserted,
                     res_o.inserted);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        expected_verdicts.push_back(predict_verdict(req_i));
        void'(pending_reqs.pop_front());
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DRAIN_RATE:  rate_cfg = val[29:0];
      REG_BURST_LIMIT: burst_cfg = val[19:0];
      REG_NO_DELAY:    nodelay_cfg = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_verdicts.size() > 0 || busy)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send(input logic [63:0] k, input logic [31:0] t);
    req_t r;
    r.flow_key = k;
    r.now_ms = t;
    pending_reqs.push_back(r);
  endtask

  // Mostly known flows at a steady pace, with idle jumps, reversals and noise.
  task automatic random_traffic(input int n, input int fresh_pct);
    logic [63:0] k;
    int sel;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(1, 100) <= fresh_pct) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(0, 39)];
      sel = $urandom_range(0, 99);
      if (sel < 6) clock_ms += 32'd60000 + $urandom_range(0, 200000);
      else if (sel < 9) clock_ms = $urandom;
      else if (sel < 12) clock_ms -= $urandom_range(0, 3000);
      else clock_ms += $urandom_range(0, 1500);
      send(k, clock_ms);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) live_tab[i] = 0;
    mru = 0; lru = 0; n_live = 0;
    rate_cfg = DRAIN_RATE_RST; burst_cfg = '0; nodelay_cfg = 1'b0;
    errors = 0; burst_left = 0; gap_left = 0;
    start = 1'b0; req_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 40; i++) key_pool[i] = {$urandom, $urandom};
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(64'd0, 32'd0);
    send(64'd0, 32'd0);
    send('1, 32'hFFFF_FFFF);
    send('1, 32'd5);
    send(64'd0, 32'd500);
    send(64'h8000_0000_0000_0001, 32'h7FFF_FFFF);
    send(64'h8000_0000_0000_0001, 32'hFFFF_FFFF);
    send(64'd0, 32'h8000_01F4);
    send(64'h1234, 32'h8001_0000);
    wait_idle();
    reg_write(REG_BURST_LIMIT, 32'd2);
    send(64'h55, 32'd100);
    send(64'h55, 32'd100);
    send(64'h55, 32'd100);
    send(64'h55, 32'd300);
    send(64'h55, 32'd400);
    wait_idle();
    reg_write(REG_NO_DELAY, 32'd1);
    send(64'h55, 32'd400);
    send(64'h55, 32'd70000);
    send(64'h66, 32'd200000);
    wait_idle();

    reg_write(REG_NO_DELAY, 32'd0);
    reg_write(REG_DRAIN_RATE, 32'd1);
    reg_write(REG_BURST_LIMIT, 32'd5);
    random_traffic(150, 10);
    wait_idle();

    // Overflow the table so that flows are evicted by force.
    reg_write(REG_DRAIN_RATE, 32'd1000000000);
    reg_write(REG_BURST_LIMIT, 32'd1000000);
    for (int j = 0; j < 300; j++) begin
      clock_ms += $urandom_range(0, 20);
      send({$urandom, $urandom}, clock_ms);
    end
    random_traffic(100, 5);
    wait_idle();

    reg_write(REG_DRAIN_RATE, 32'd500);
    reg_write(REG_BURST_LIMIT, 32'd0);
    random_traffic(120, 10);
    wait_idle();

    reg_write(REG_DRAIN_RATE, 32'd2000);
    reg_write(REG_BURST_LIMIT, 32'd3);
    reg_write(REG_NO_DELAY, 32'd1);
    random_traffic(120, 10);
    wait_idle();

    reg_write(REG_DRAIN_RATE, 32'h3FFF_FFFF);
    reg_write(REG_NO_DELAY, 32'd0);
    random_traffic(100, 15);
    wait_idle();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
